/* hdl/yrgb_pkg.sv */
// Shared widths, register indexes, register reset values and stage enables for the YUY2 to RGB converter.
package yrgb_pkg;

   localparam int LumaGainWidth = 21;
   localparam int LumaBiasWidth = 25;
   localparam int HueTermWidth  = 16;
   localparam int CsrDataWidth  = 25;
   localparam int CsrIndexWidth = 2;

   // Width of a chroma contribution and of a channel sum
   localparam int ChanWidth = 29;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] RegLumaGain = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegLumaBias = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegCosTerm  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegSinTerm  = 2'd3;

   // Register reset values
   localparam logic signed [LumaGainWidth-1:0] LumaGainReset = 21'sd76288;
   localparam logic signed [LumaBiasWidth-1:0] LumaBiasReset = 25'sd32768;
   localparam logic signed [HueTermWidth-1:0]  CosTermReset  = 16'sd256;
   localparam logic signed [HueTermWidth-1:0]  SinTermReset  = 16'sd0;

   // Load enables for the three pipeline stages shared by the lanes
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

/* hdl/yrgb_chroma.sv */
// Chroma path: re-center U/V, hue rotation, then BT.601 red/green/blue contributions.
module yrgb_chroma import yrgb_pkg::*; (
   input  logic                          clock,
   input  stage_en_type                  en,
   input  logic [7:0]                    chroma_blue,
   input  logic [7:0]                    chroma_red,
   input  logic signed [HueTermWidth-1:0] cos_term,
   input  logic signed [HueTermWidth-1:0] sin_term,
   output logic signed [ChanWidth-1:0]   cr,
   output logic signed [ChanWidth-1:0]   cg,
   output logic signed [ChanWidth-1:0]   cb
);

   localparam logic signed [ChanWidth-1:0] CoefR  = 29'sd409;
   localparam logic signed [ChanWidth-1:0] CoefGu = 29'sd100;
   localparam logic signed [ChanWidth-1:0] CoefGv = 29'sd208;
   localparam logic signed [ChanWidth-1:0] CoefB  = 29'sd516;

   logic signed [8:0]  u_c;
   logic signed [8:0]  v_c;
   logic signed [24:0] uc_in, us_in, vc_in, vs_in;
   logic signed [24:0] uc_ff, us_ff, vc_ff, vs_ff;
   logic signed [25:0] d_sum;
   logic signed [25:0] e_sum;
   logic signed [17:0] d_in, e_in, d_ff, e_ff;
   logic signed [ChanWidth-1:0] d_w, e_w;
   logic signed [ChanWidth-1:0] cr_in, cg_in, cb_in;
   logic signed [ChanWidth-1:0] cr_ff, cg_ff, cb_ff;

   // stage 1: four hue products
   assign u_c   = $signed({1'b0, chroma_blue}) - 9'sd128;
   assign v_c   = $signed({1'b0, chroma_red}) - 9'sd128;
   assign uc_in = u_c * cos_term;
   assign us_in = u_c * sin_term;
   assign vc_in = v_c * cos_term;
   assign vs_in = v_c * sin_term;

   // stage 2: rotated chroma, floor divide by 256
   assign d_sum = uc_ff + vs_ff;
   assign e_sum = vc_ff + us_ff;
   assign d_in  = d_sum[25:8];
   assign e_in  = e_sum[25:8];

   // stage 3: constant coefficient terms
   assign d_w   = d_ff;
   assign e_w   = e_ff;
   assign cr_in = e_w * CoefR;
   assign cg_in = -(d_w * CoefGu) - (e_w * CoefGv);
   assign cb_in = d_w * CoefB;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         uc_ff <= uc_in;
         us_ff <= us_in;
         vc_ff <= vc_in;
         vs_ff <= vs_in;
      end
      if (en.s2) begin
         d_ff <= d_in;
         e_ff <= e_in;
      end
      if (en.s3) begin
         cr_ff <= cr_in;
         cg_ff <= cg_in;
         cb_ff <= cb_in;
      end
   end

   assign cr = cr_ff;
   assign cg = cg_ff;
   assign cb = cb_ff;

endmodule

/* hdl/yrgb_lane.sv */
// One pixel lane: luma scaling and per-channel sum with clamp to 8 bits.
module yrgb_lane import yrgb_pkg::*; (
   input  logic                            clock,
   input  stage_en_type                    en,
   input  logic [7:0]                      luma,
   input  logic signed [LumaGainWidth-1:0] luma_gain,
   input  logic signed [LumaBiasWidth-1:0] luma_bias,
   input  logic signed [ChanWidth-1:0]     cr,
   input  logic signed [ChanWidth-1:0]     cg,
   input  logic signed [ChanWidth-1:0]     cb,
   output logic [7:0]                      red,
   output logic [7:0]                      green,
   output logic [7:0]                      blue
);

   function automatic logic [7:0] clamp_chan(input logic signed [ChanWidth-1:0] s);
      logic [7:0] r;
      if (s < 0) begin
         r = 8'd0;
      end else if (s > 29'sd65535) begin
         r = 8'hff;
      end else begin
         r = s[15:8];
      end
      return r;
   endfunction

   logic signed [8:0]  y_off;
   logic signed [29:0] prod_in, prod_ff;
   logic signed [30:0] scaled;
   logic signed [22:0] ys_in, ys_ff, ys3_ff;
   logic signed [ChanWidth-1:0] ys_w;

   // stage 1: (Y-16) * gain
   assign y_off   = $signed({1'b0, luma}) - 9'sd16;
   assign prod_in = y_off * luma_gain;

   // stage 2: add bias and rounding, floor divide by 256
   assign scaled = prod_ff + luma_bias + 31'sd128;
   assign ys_in  = scaled[30:8];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         ys_ff <= ys_in;
      end
      if (en.s3) begin
         ys3_ff <= ys_ff;
      end
   end

   // final sums feed the output register in the top level
   assign ys_w  = ys3_ff;
   assign red   = clamp_chan(ys_w + cr);
   assign green = clamp_chan(ys_w + cg);
   assign blue  = clamp_chan(ys_w + cb);

endmodule

/* hdl/yuy2_to_rgb_color_adjust.sv */
// Top level: YUY2 pair to two RGB888 pixels with brightness, contrast, hue and saturation.
// Each input word is one YUY2 group (two luma bytes, shared U and V); each output word holds
// two RGB pixels and the frame-end flag. The block takes one word per clock unless stalled
// and passes it through three pipeline stages (multiply, round and rotate, coefficient terms)
// followed by the output register, where both pixel lanes and the shared chroma path meet.
// Every stage holds a valid bit and advances on its own, so a stalled output only blocks the
// input once all stages are full. Registers take effect on the next word; write them idle.
module yuy2_to_rgb_color_adjust import yrgb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_luma_first,
   input  logic [7:0]               req_chroma_blue,
   input  logic [7:0]               req_luma_second,
   input  logic [7:0]               req_chroma_red,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_red_first,
   output logic [7:0]               rsp_green_first,
   output logic [7:0]               rsp_blue_first,
   output logic [7:0]               rsp_red_second,
   output logic [7:0]               rsp_green_second,
   output logic [7:0]               rsp_blue_second,
   output logic                     rsp_pair_last,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic signed [LumaGainWidth-1:0] luma_gain_ff;
   logic signed [LumaBiasWidth-1:0] luma_bias_ff;
   logic signed [HueTermWidth-1:0]  cos_term_ff;
   logic signed [HueTermWidth-1:0]  sin_term_ff;

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic fe1_ff, fe2_ff, fe3_ff;
   logic adv1, adv2, adv3, adv_out;
   stage_en_type en;

   logic signed [ChanWidth-1:0] cr, cg, cb;
   logic [7:0] red_a, green_a, blue_a, red_b, green_b, blue_b;
   logic [7:0] red_a_ff, green_a_ff, blue_a_ff, red_b_ff, green_b_ff, blue_b_ff;
   logic pair_last_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         luma_gain_ff <= LumaGainReset;
         luma_bias_ff <= LumaBiasReset;
         cos_term_ff  <= CosTermReset;
         sin_term_ff  <= SinTermReset;
      end else if (csr_write_en) begin
         case (csr_index)
            RegLumaGain: luma_gain_ff <= csr_data[LumaGainWidth-1:0];
            RegLumaBias: luma_bias_ff <= csr_data[LumaBiasWidth-1:0];
            RegCosTerm:  cos_term_ff  <= csr_data[HueTermWidth-1:0];
            RegSinTerm:  sin_term_ff  <= csr_data[HueTermWidth-1:0];
            default: ;
         endcase
      end
   end

   // a stage moves when it is empty or the next one moves
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv3      = !v3_ff || adv_out;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;

   assign en.s1 = adv1;
   assign en.s2 = adv2;
   assign en.s3 = adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1)    v1_ff        <= req_valid;
         if (adv2)    v2_ff        <= v1_ff;
         if (adv3)    v3_ff        <= v2_ff;
         if (adv_out) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) fe1_ff <= req_frame_end;
      if (adv2) fe2_ff <= fe1_ff;
      if (adv3) fe3_ff <= fe2_ff;
   end

   yrgb_chroma u_chroma (
      .clock       (clock),
      .en          (en),
      .chroma_blue (req_chroma_blue),
      .chroma_red  (req_chroma_red),
      .cos_term    (cos_term_ff),
      .sin_term    (sin_term_ff),
      .cr          (cr),
      .cg          (cg),
      .cb          (cb)
   );

   yrgb_lane u_lane_first (
      .clock     (clock),
      .en        (en),
      .luma      (req_luma_first),
      .luma_gain (luma_gain_ff),
      .luma_bias (luma_bias_ff),
      .cr        (cr),
      .cg        (cg),
      .cb        (cb),
      .red       (red_a),
      .green     (green_a),
      .blue      (blue_a)
   );

   yrgb_lane u_lane_second (
      .clock     (clock),
      .en        (en),
      .luma      (req_luma_second),
      .luma_gain (luma_gain_ff),
      .luma_bias (luma_bias_ff),
      .cr        (cr),
      .cg        (cg),
      .cb        (cb),
      .red       (red_b),
      .green     (green_b),
      .blue      (blue_b)
   );

   // output register joins both lanes into one word
   always_ff @(posedge clock) begin
      if (adv_out) begin
         red_a_ff     <= red_a;
         green_a_ff   <= green_a;
         blue_a_ff    <= blue_a;
         red_b_ff     <= red_b;
         green_b_ff   <= green_b;
         blue_b_ff    <= blue_b;
         pair_last_ff <= fe3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_first    = red_a_ff;
   assign rsp_green_first  = green_a_ff;
   assign rsp_blue_first   = blue_a_ff;
   assign rsp_red_second   = red_b_ff;
   assign rsp_green_second = green_b_ff;
   assign rsp_blue_second  = blue_b_ff;
   assign rsp_pair_last    = pair_last_ff;

`ifndef SYNTHESIS
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("input stalled with first stage empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word lost at first stage");

   a_drain_out: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("last stage did not reach output register");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(red_a_ff) && $stable(blue_b_ff)))
      else $error("stalled output word changed");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output valid after reset");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the YUY2 to RGB888 color-adjust converter.
`timescale 1ns / 100ps

module tb_top;
   import yrgb_pkg::*;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       pair_last;
   } rgb_pair_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_luma_first;
   logic [7:0]               req_chroma_blue;
   logic [7:0]               req_luma_second;
   logic [7:0]               req_chroma_red;
   logic                     req_frame_end;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [7:0]               rsp_red_first;
   logic [7:0]               rsp_green_first;
   logic [7:0]               rsp_blue_first;
   logic [7:0]               rsp_red_second;
   logic [7:0]               rsp_green_second;
   logic [7:0]               rsp_blue_second;
   logic                     rsp_pair_last;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   // Predictor copy of the adjustment registers
   logic signed [LumaGainWidth-1:0] luma_gain_q;
   logic signed [LumaBiasWidth-1:0] luma_bias_q;
   logic signed [HueTermWidth-1:0]  cos_term_q;
   logic signed [HueTermWidth-1:0]  sin_term_q;

   rgb_pair_type pending_pixels[$];
   int           mismatch_count;
   bit           quiet;

   yuy2_to_rgb_color_adjust u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_luma_first   (req_luma_first),
      .req_chroma_blue  (req_chroma_blue),
      .req_luma_second  (req_luma_second),
      .req_chroma_red   (req_chroma_red),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_first    (rsp_red_first),
      .rsp_green_first  (rsp_green_first),
      .rsp_blue_first   (rsp_blue_first),
      .rsp_red_second   (rsp_red_second),
      .rsp_green_second (rsp_green_second),
      .rsp_blue_second  (rsp_blue_second),
      .rsp_pair_last    (rsp_pair_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // floor((Y - 16) * gain + bias + 128) / 256)
   function automatic longint scale_luma(logic [7:0] y);
      longint t;
      t = (longint'(y) - 16) * longint'(luma_gain_q) + longint'(luma_bias_q) + 128;
      return t >>> 8;
   endfunction

   function automatic logic [7:0] clip_channel(longint s);
      if (s < 0)
         return 8'd0;
      if (s > 64'sd65535)
         return 8'hff;
      return s[15:8];
   endfunction

   function automatic rgb_pair_type convert_pair(logic [7:0] y1, logic [7:0] cb,
                                                 logic [7:0] y2, logic [7:0] cr, logic fe);
      longint       ya, yb, u, v, d, e, rr, gg, bb;
      rgb_pair_type px;
      ya = scale_luma(y1);
      yb = scale_luma(y2);
      u  = longint'(cb) - 128;
      v  = longint'(cr) - 128;
      // hue rotation, floored to whole units
      d  = (u * longint'(cos_term_q) + v * longint'(sin_term_q)) >>> 8;
      e  = (v * longint'(cos_term_q) + u * longint'(sin_term_q)) >>> 8;
      rr = 409 * e;
      gg = -100 * d - 208 * e;
      bb = 516 * d;
      px.red_first    = clip_channel(ya + rr);
      px.green_first  = clip_channel(ya + gg);
      px.blue_first   = clip_channel(ya + bb);
      px.red_second   = clip_channel(yb + rr);
      px.green_second = clip_channel(yb + gg);
      px.blue_second  = clip_channel(yb + bb);
      px.pair_last    = fe;
      return px;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rgb_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected output word");
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_channel("red_first", want.red_first, rsp_red_first);
            check_channel("green_first", want.green_first, rsp_green_first);
            check_channel("blue_first", want.blue_first, rsp_blue_first);
            check_channel("red_second", want.red_second, rsp_red_second);
            check_channel("green_second", want.green_second, rsp_green_second);
            check_channel("blue_second", want.blue_second, rsp_blue_second);
            check_channel("pair_last", 8'(want.pair_last), 8'(rsp_pair_last));
         end
      end
   end

   // Output backpressure: mostly free-flowing, short stalls, an occasional long one
   initial begin
      int run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic int gap_len();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_pair(logic [7:0] y1, logic [7:0] cb, logic [7:0] y2, logic [7:0] cr,
                            logic fe);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_luma_first  <= y1;
      req_chroma_blue <= cb;
      req_luma_second <= y2;
      req_chroma_red  <= cr;
      req_frame_end   <= fe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(convert_pair(y1, cb, y2, cr, fe));
   endtask

   task automatic send_random_pair();
      send_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                $urandom_range(0, 15) == 0);
   endtask

   // Drop valid and wait for every outstanding word to come back
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         $error("%0d output words never arrived", pending_pixels.size());
         mismatch_count++;
         pending_pixels.delete();
      end
   endtask

   function automatic int reg_width(logic [CsrIndexWidth-1:0] idx);
      case (idx)
         RegLumaGain: return LumaGainWidth;
         RegLumaBias: return LumaBiasWidth;
         default:     return HueTermWidth;
      endcase
   endfunction

   function automatic logic [CsrDataWidth-1:0] reg_extreme(int width, bit top);
      if (top)
         return CsrDataWidth'((64'sd1 <<< (width - 1)) - 1);
      return CsrDataWidth'(-(64'sd1 <<< (width - 1)));
   endfunction

   // Block is idle when this is called; the value is masked to the register width
   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      case (idx)
         RegLumaGain: luma_gain_q = value[LumaGainWidth-1:0];
         RegLumaBias: luma_bias_q = value[LumaBiasWidth-1:0];
         RegCosTerm:  cos_term_q  = value[HueTermWidth-1:0];
         RegSinTerm:  sin_term_q  = value[HueTermWidth-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [CsrDataWidth-1:0] pick_reg_value(logic [CsrIndexWidth-1:0] idx);
      int w;
      int pick;
      w    = reg_width(idx);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return reg_extreme(w, 1'b0);
      if (pick == 1)
         return reg_extreme(w, 1'b1);
      if (pick == 2)
         return CsrDataWidth'($urandom);   // full range, junk above the width
      // values a real picture setting would give
      case (idx)
         RegLumaGain: return CsrDataWidth'($urandom_range(0, 160000));
         RegLumaBias: return CsrDataWidth'(int'($urandom_range(0, 400000)) - 200000);
         default:     return CsrDataWidth'(int'($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_settings();
      send_pair(8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
      send_pair(8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
      send_pair(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
      send_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
      send_pair(8'd255, 8'd128, 8'd0, 8'd128, 1'b1);
      send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
      drain_pipeline();
   endtask

   // Register extremes drive every channel into both saturation limits
   task automatic test_register_extremes();
      write_reg(RegLumaGain, reg_extreme(LumaGainWidth, 1'b1));
      write_reg(RegLumaBias, reg_extreme(LumaBiasWidth, 1'b1));
      send_pair(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
      send_pair(8'd16, 8'd128, 8'd15, 8'd128, 1'b1);
      send_pair(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
      drain_pipeline();
      write_reg(RegLumaGain, reg_extreme(LumaGainWidth, 1'b0));
      write_reg(RegLumaBias, reg_extreme(LumaBiasWidth, 1'b0));
      send_pair(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
      send_pair(8'd255, 8'd128, 8'd16, 8'd128, 1'b0);
      send_pair(8'd17, 8'd255, 8'd254, 8'd0, 1'b1);
      drain_pipeline();
      // upper data bits are junk and must be dropped
      write_reg(RegLumaGain, {4'hf, LumaGainReset});
      write_reg(RegLumaBias, LumaBiasReset);
      write_reg(RegCosTerm, reg_extreme(HueTermWidth, 1'b0));
      write_reg(RegSinTerm, reg_extreme(HueTermWidth, 1'b1));
      send_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
      send_pair(8'd60, 8'd255, 8'd200, 8'd0, 1'b0);
      send_pair(8'd235, 8'd129, 8'd16, 8'd127, 1'b1);
      drain_pipeline();
      write_reg(RegCosTerm, reg_extreme(HueTermWidth, 1'b1));
      write_reg(RegSinTerm, {9'h1a5, HueTermWidth'(reg_extreme(HueTermWidth, 1'b0))});
      send_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
      send_pair(8'd60, 8'd255, 8'd200, 8'd0, 1'b1);
      send_pair(8'd235, 8'd127, 8'd16, 8'd129, 1'b0);
      drain_pipeline();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 12; phase++) begin
         for (int r = 0; r < 4; r++)
            write_reg(CsrIndexWidth'(r), pick_reg_value(CsrIndexWidth'(r)));
         for (int n = 0; n < 150; n++) begin
            // hold the sender until everything in flight has come back
            if (phase % 4 == 1 && n == 75)
               drain_pipeline();
            send_random_pair();
         end
         drain_pipeline();
      end
   endtask

   task automatic test_back_to_back();
      write_reg(RegLumaGain, LumaGainReset);
      write_reg(RegLumaBias, LumaBiasReset);
      write_reg(RegCosTerm, CosTermReset);
      write_reg(RegSinTerm, SinTermReset);
      quiet = 1'b1;
      repeat (50) send_random_pair();
      quiet = 1'b0;
      drain_pipeline();
   endtask

   initial begin
      reset           = 1'b1;
      quiet           = 1'b0;
      mismatch_count  = 0;
      req_valid       = 1'b0;
      req_luma_first  = '0;
      req_chroma_blue = '0;
      req_luma_second = '0;
      req_chroma_red  = '0;
      req_frame_end   = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = RegLumaGain;
      csr_data        = '0;
      luma_gain_q     = LumaGainReset;
      luma_bias_q     = LumaBiasReset;
      cos_term_q      = CosTermReset;
      sin_term_q      = SinTermReset;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_register_extremes();
      test_random_settings();
      test_back_to_back();

      drain_pipeline();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
hdl/yrgb_pkg.sv
hdl/yrgb_chroma.sv
hdl/yrgb_lane.sv
hdl/yuy2_to_rgb_color_adjust.sv
sim/tb_top.sv
